>>> design/cau_pkg.sv
// Shared types for the complex arithmetic unit: operation codes and status codes.
// No dependencies.
package cau_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_CONJ  = 3'd4,
        OP_NEG   = 3'd5,
        OP_ABS   = 3'd6,
        OP_EQUAL = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

endpackage

>>> design/complex_arithmetic_unit.sv
// Complex arithmetic unit: pipelined add, sub, mul, div, conj, neg, abs and equal
// on fixed-point complex words. Depends on cau_pkg.
//
//  channel | direction | tdata                              | tuser
//  s_*     | in        | a_re, a_im, b_re, b_im (low first)  | req_type
//  m_*     | out       | res_re, res_im (low first)          | is_equal, status (low first)
//
// One word enters per cycle while s_tready is high; each word passes four front
// stages, DATA_WIDTH+2 restoring divide steps and the output register.
// The divide-step chain, one quotient bit per stage, is the longest part of the
// pipeline; the square root runs in the first DATA_WIDTH of those stages alongside it.
// Reset clears only the valid bits. A stall on m_tready fills a one-word skid
// register; only once that is full does the whole pipeline hold and s_tready drop.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,  // a_re, a_im, b_re, b_im
    input  logic [2:0]                              s_tuser,  // req_type
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]       m_tdata,  // res_re, res_im
    output logic [2:0]                              m_tuser   // is_equal, status
);

    localparam int W       = DATA_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int MW      = 2 * W;          // product / magnitude width
    localparam int NS      = W + 2;          // divide steps (quotient bits)
    localparam int CW      = MW + W + F + 3; // divide remainder width
    localparam int SRW     = MW + 2;         // square-root remainder width
    localparam int OUT_TDW = ((2*DATA_WIDTH+7)/8)*8;

    localparam logic [MW:0]  NEG_LIM = (MW+1)'(1) << (W - 1);
    localparam logic [MW:0]  POS_LIM = NEG_LIM - (MW+1)'(1);
    localparam logic [MW:0]  HALF    = ((MW+1)'(1) << F) >> 1;
    localparam logic [W-1:0] S_MIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] S_MAX   = ~S_MIN;

    // clamp a W+1 bit two's complement value; top bit of result flags saturation
    function automatic logic [W:0] sat_s(input logic [W:0] v);
        logic [W:0] r;
        if (v[W] != v[W-1])
            r = {1'b1, (v[W] ? S_MIN : S_MAX)};
        else
            r = {1'b0, v[W-1:0]};
        return r;
    endfunction

    // sign/magnitude to two's complement with clamping
    function automatic logic [W:0] sat_sm(input logic neg, input logic [MW:0] mag);
        logic [W:0]   r;
        logic [W-1:0] m;
        m = mag[W-1:0];
        if (neg)
        begin
            if (mag > NEG_LIM)
                r = {1'b1, S_MIN};
            else
                r = {1'b0, -m};
        end
        else
        begin
            if (mag > POS_LIM)
                r = {1'b1, S_MAX};
            else
                r = {1'b0, m};
        end
        return r;
    endfunction

    logic en;
    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------- stage 1: products and the simple operations ----------------
    logic signed [W-1:0] ar, ai, br, bi;
    logic [W:0]          ar_x, ai_x, br_x, bi_x;
    cau_pkg::op_t        in_op;
    logic [W:0]          pre_re_w, pre_im_w;
    logic [W-1:0]        pre_re_next, pre_im_next;
    cau_pkg::status_t    pre_st_next;
    logic                eq_next;

    assign ar    = s_tdata[W-1:0];
    assign ai    = s_tdata[2*W-1:W];
    assign br    = s_tdata[3*W-1:2*W];
    assign bi    = s_tdata[4*W-1:3*W];
    assign ar_x  = {ar[W-1], ar};
    assign ai_x  = {ai[W-1], ai};
    assign br_x  = {br[W-1], br};
    assign bi_x  = {bi[W-1], bi};
    assign in_op = cau_pkg::op_t'(s_tuser);

    always_comb
    begin
        pre_re_w = '0;
        pre_im_w = '0;
        eq_next  = 1'b0;
        unique case (in_op)
            cau_pkg::OP_ADD:
            begin
                pre_re_w = sat_s(ar_x + br_x);
                pre_im_w = sat_s(ai_x + bi_x);
            end
            cau_pkg::OP_SUB:
            begin
                pre_re_w = sat_s(ar_x - br_x);
                pre_im_w = sat_s(ai_x - bi_x);
            end
            cau_pkg::OP_CONJ:
            begin
                pre_re_w = {1'b0, ar};
                pre_im_w = sat_s(-ai_x);
            end
            cau_pkg::OP_NEG:
            begin
                pre_re_w = sat_s(-ar_x);
                pre_im_w = sat_s(-ai_x);
            end
            cau_pkg::OP_EQUAL:
            begin
                eq_next = (ar == br) && (ai == bi);
            end
            default:
            begin
                pre_re_w = '0;
                pre_im_w = '0;
            end
        endcase
        pre_re_next = pre_re_w[W-1:0];
        pre_im_next = pre_im_w[W-1:0];
        pre_st_next = (pre_re_w[W] || pre_im_w[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end

    logic                s1_valid_reg;
    cau_pkg::op_t        s1_op_reg;
    logic signed [MW-1:0] s1_prr_reg, s1_pii_reg, s1_pri_reg, s1_pir_reg;
    logic signed [MW-1:0] s1_paa_reg, s1_pbb_reg, s1_pcc_reg, s1_pdd_reg;
    logic [W-1:0]        s1_pre_re_reg, s1_pre_im_reg;
    cau_pkg::status_t    s1_pre_st_reg;
    logic                s1_eq_reg;

    // ---------------- stage 2: sums of products ----------------
    logic                s2_valid_reg;
    cau_pkg::op_t        s2_op_reg;
    logic [MW:0]         s2_nre_reg, s2_nim_reg;
    logic [MW-1:0]       s2_den_reg, s2_sq_reg;
    logic [W-1:0]        s2_pre_re_reg, s2_pre_im_reg;
    cau_pkg::status_t    s2_pre_st_reg;
    logic                s2_eq_reg;
    logic [MW:0]         nre_next, nim_next;
    logic [MW:0]         prr_x, pii_x, pri_x, pir_x;

    assign prr_x = {s1_prr_reg[MW-1], s1_prr_reg};
    assign pii_x = {s1_pii_reg[MW-1], s1_pii_reg};
    assign pri_x = {s1_pri_reg[MW-1], s1_pri_reg};
    assign pir_x = {s1_pir_reg[MW-1], s1_pir_reg};

    always_comb
    begin
        if (s1_op_reg == cau_pkg::OP_MUL)
        begin
            nre_next = prr_x - pii_x;
            nim_next = pri_x + pir_x;
        end
        else
        begin
            nre_next = prr_x + pii_x;
            nim_next = pir_x - pri_x;
        end
    end

    // ---------------- stage 3: sign and magnitude ----------------
    logic                s3_valid_reg;
    cau_pkg::op_t        s3_op_reg;
    logic                s3_neg_re_reg, s3_neg_im_reg;
    logic [MW-1:0]       s3_mag_re_reg, s3_mag_im_reg;
    logic [MW-1:0]       s3_den_reg, s3_sq_reg;
    logic [W-1:0]        s3_pre_re_reg, s3_pre_im_reg;
    cau_pkg::status_t    s3_pre_st_reg;
    logic                s3_eq_reg;
    logic [MW:0]         nre_neg, nim_neg;
    logic [MW-1:0]       mag_re_next, mag_im_next;

    assign nre_neg     = -s2_nre_reg;
    assign nim_neg     = -s2_nim_reg;
    assign mag_re_next = s2_nre_reg[MW] ? nre_neg[MW-1:0] : s2_nre_reg[MW-1:0];
    assign mag_im_next = s2_nim_reg[MW] ? nim_neg[MW-1:0] : s2_nim_reg[MW-1:0];

    // ---------------- step pipeline: index 0 is the set-up stage ----------------
    logic                v_reg      [0:NS];
    cau_pkg::op_t        op_reg     [0:NS];
    logic [W-1:0]        pre_re_reg [0:NS];
    logic [W-1:0]        pre_im_reg [0:NS];
    cau_pkg::status_t    pre_st_reg [0:NS];
    logic                eq_reg     [0:NS];
    logic                neg_re_reg [0:NS];
    logic                neg_im_reg [0:NS];
    logic                ovf_re_reg [0:NS];
    logic                ovf_im_reg [0:NS];
    logic                dz_reg     [0:NS];
    logic [MW-1:0]       den_reg    [0:NS];
    logic [CW-1:0]       rre_reg    [0:NS];
    logic [CW-1:0]       rim_reg    [0:NS];
    logic [NS-1:0]       qre_reg    [0:NS];
    logic [NS-1:0]       qim_reg    [0:NS];
    logic [SRW-1:0]      srem_reg   [0:NS];
    logic [W-1:0]        root_reg   [0:NS];

    // set-up stage: multiply rounding, dividend alignment, overflow pre-check
    logic [MW:0]         mrnd_re, mrnd_im;
    logic [W:0]          msat_re, msat_im;
    logic [CW-1:0]       rre_next, rim_next, den_top;
    logic [W-1:0]        su_re_next, su_im_next;
    cau_pkg::status_t    su_st_next;

    always_comb
    begin
        mrnd_re  = ({1'b0, s3_mag_re_reg} + HALF) >> F;
        mrnd_im  = ({1'b0, s3_mag_im_reg} + HALF) >> F;
        msat_re  = sat_sm(s3_neg_re_reg, mrnd_re);
        msat_im  = sat_sm(s3_neg_im_reg, mrnd_im);
        rre_next = CW'(s3_mag_re_reg) << (F + 1);
        rim_next = CW'(s3_mag_im_reg) << (F + 1);
        den_top  = CW'(s3_den_reg) << NS;
        if (s3_op_reg == cau_pkg::OP_MUL)
        begin
            su_re_next = msat_re[W-1:0];
            su_im_next = msat_im[W-1:0];
            su_st_next = (msat_re[W] || msat_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
        else
        begin
            su_re_next = s3_pre_re_reg;
            su_im_next = s3_pre_im_reg;
            su_st_next = s3_pre_st_reg;
        end
    end

    // front stages: valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            v_reg[0]     <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            v_reg[0]     <= s3_valid_reg;
        end
    end

    // front stages: payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg     <= in_op;
            s1_prr_reg    <= MW'(ar) * MW'(br);
            s1_pii_reg    <= MW'(ai) * MW'(bi);
            s1_pri_reg    <= MW'(ar) * MW'(bi);
            s1_pir_reg    <= MW'(ai) * MW'(br);
            s1_paa_reg    <= MW'(ar) * MW'(ar);
            s1_pbb_reg    <= MW'(ai) * MW'(ai);
            s1_pcc_reg    <= MW'(br) * MW'(br);
            s1_pdd_reg    <= MW'(bi) * MW'(bi);
            s1_pre_re_reg <= pre_re_next;
            s1_pre_im_reg <= pre_im_next;
            s1_pre_st_reg <= pre_st_next;
            s1_eq_reg     <= eq_next;

            s2_op_reg     <= s1_op_reg;
            s2_nre_reg    <= nre_next;
            s2_nim_reg    <= nim_next;
            s2_den_reg    <= s1_pcc_reg + s1_pdd_reg;
            s2_sq_reg     <= s1_paa_reg + s1_pbb_reg;
            s2_pre_re_reg <= s1_pre_re_reg;
            s2_pre_im_reg <= s1_pre_im_reg;
            s2_pre_st_reg <= s1_pre_st_reg;
            s2_eq_reg     <= s1_eq_reg;

            s3_op_reg     <= s2_op_reg;
            s3_neg_re_reg <= s2_nre_reg[MW];
            s3_neg_im_reg <= s2_nim_reg[MW];
            s3_mag_re_reg <= mag_re_next;
            s3_mag_im_reg <= mag_im_next;
            s3_den_reg    <= s2_den_reg;
            s3_sq_reg     <= s2_sq_reg;
            s3_pre_re_reg <= s2_pre_re_reg;
            s3_pre_im_reg <= s2_pre_im_reg;
            s3_pre_st_reg <= s2_pre_st_reg;
            s3_eq_reg     <= s2_eq_reg;

            op_reg[0]     <= s3_op_reg;
            pre_re_reg[0] <= su_re_next;
            pre_im_reg[0] <= su_im_next;
            pre_st_reg[0] <= su_st_next;
            eq_reg[0]     <= s3_eq_reg;
            neg_re_reg[0] <= s3_neg_re_reg;
            neg_im_reg[0] <= s3_neg_im_reg;
            ovf_re_reg[0] <= rre_next >= den_top;
            ovf_im_reg[0] <= rim_next >= den_top;
            dz_reg[0]     <= (s3_den_reg == '0);
            den_reg[0]    <= s3_den_reg;
            rre_reg[0]    <= rre_next;
            rim_reg[0]    <= rim_next;
            qre_reg[0]    <= '0;
            qim_reg[0]    <= '0;
            srem_reg[0]   <= SRW'(s3_sq_reg);
            root_reg[0]   <= '0;
        end
    end

    // one restoring divide step per stage; a square-root digit in the first W stages
    for (genvar k = 0; k < NS; k++)
    begin : g_step
        localparam int J = NS - 1 - k;
        logic [CW-1:0]  dv;
        logic           bre, bim;
        logic [CW-1:0]  rre_step_next, rim_step_next;
        logic [NS-1:0]  qre_step_next, qim_step_next;
        logic [SRW-1:0] srem_step_next;
        logic [W-1:0]   root_step_next;

        always_comb
        begin
            dv            = CW'(den_reg[k]) << J;
            bre           = rre_reg[k] >= dv;
            bim           = rim_reg[k] >= dv;
            rre_step_next = bre ? rre_reg[k] - dv : rre_reg[k];
            rim_step_next = bim ? rim_reg[k] - dv : rim_reg[k];
            qre_step_next = qre_reg[k] | (NS'(bre) << J);
            qim_step_next = qim_reg[k] | (NS'(bim) << J);
        end

        if (k < W)
        begin : g_sqrt
            localparam int I = W - 1 - k;
            logic [SRW-1:0] trial;
            always_comb
            begin
                trial = (SRW'(root_reg[k]) << (I + 1)) + (SRW'(1) << (2 * I));
                if (srem_reg[k] >= trial)
                begin
                    srem_step_next = srem_reg[k] - trial;
                    root_step_next = root_reg[k] | (W'(1) << I);
                end
                else
                begin
                    srem_step_next = srem_reg[k];
                    root_step_next = root_reg[k];
                end
            end
        end
        else
        begin : g_hold
            assign srem_step_next = srem_reg[k];
            assign root_step_next = root_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                op_reg[k+1]     <= op_reg[k];
                pre_re_reg[k+1] <= pre_re_reg[k];
                pre_im_reg[k+1] <= pre_im_reg[k];
                pre_st_reg[k+1] <= pre_st_reg[k];
                eq_reg[k+1]     <= eq_reg[k];
                neg_re_reg[k+1] <= neg_re_reg[k];
                neg_im_reg[k+1] <= neg_im_reg[k];
                ovf_re_reg[k+1] <= ovf_re_reg[k];
                ovf_im_reg[k+1] <= ovf_im_reg[k];
                dz_reg[k+1]     <= dz_reg[k];
                den_reg[k+1]    <= den_reg[k];
                rre_reg[k+1]    <= rre_step_next;
                rim_reg[k+1]    <= rim_step_next;
                qre_reg[k+1]    <= qre_step_next;
                qim_reg[k+1]    <= qim_step_next;
                srem_reg[k+1]   <= srem_step_next;
                root_reg[k+1]   <= root_step_next;
            end
        end
    end

    // ---------------- final selection: round quotients, clamp, pick by op ----------------
    logic [NS:0]       qre_inc, qim_inc;
    logic [W:0]        dsat_re, dsat_im, asat;
    logic [W-1:0]      fin_re, fin_im;
    cau_pkg::status_t  fin_st;
    logic              fin_eq;

    always_comb
    begin
        qre_inc = {1'b0, qre_reg[NS]} + (NS+1)'(1);
        qim_inc = {1'b0, qim_reg[NS]} + (NS+1)'(1);
        dsat_re = ovf_re_reg[NS] ? {1'b1, (neg_re_reg[NS] ? S_MIN : S_MAX)}
                                 : sat_sm(neg_re_reg[NS], (MW+1)'(qre_inc[NS:1]));
        dsat_im = ovf_im_reg[NS] ? {1'b1, (neg_im_reg[NS] ? S_MIN : S_MAX)}
                                 : sat_sm(neg_im_reg[NS], (MW+1)'(qim_inc[NS:1]));
        asat    = sat_sm(1'b0, (MW+1)'(root_reg[NS]));
        fin_eq  = eq_reg[NS];
        unique case (op_reg[NS])
            cau_pkg::OP_DIV:
            begin
                if (dz_reg[NS])
                begin
                    fin_re = '0;
                    fin_im = '0;
                    fin_st = cau_pkg::ST_DIV_ZERO;
                end
                else
                begin
                    fin_re = dsat_re[W-1:0];
                    fin_im = dsat_im[W-1:0];
                    fin_st = (dsat_re[W] || dsat_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
                end
            end
            cau_pkg::OP_ABS:
            begin
                fin_re = asat[W-1:0];
                fin_im = '0;
                fin_st = asat[W] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            default:
            begin
                fin_re = pre_re_reg[NS];
                fin_im = pre_im_reg[NS];
                fin_st = pre_st_reg[NS];
            end
        endcase
    end

    // ---------------- output register and skid ----------------
    logic              out_valid_reg;
    logic [W-1:0]      out_re_reg, out_im_reg, skid_re_reg, skid_im_reg;
    cau_pkg::status_t  out_st_reg, skid_st_reg;
    logic              out_eq_reg, skid_eq_reg;
    logic              take_out, load_skid;

    assign take_out  = !out_valid_reg || m_tready;
    assign load_skid = !take_out && en && v_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take_out)
        begin
            // drain the skid first; the pipeline holds while it is full
            out_valid_reg  <= skid_valid_reg || v_reg[NS];
            skid_valid_reg <= 1'b0;
        end
        else if (load_skid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_out)
        begin
            out_re_reg <= skid_valid_reg ? skid_re_reg : fin_re;
            out_im_reg <= skid_valid_reg ? skid_im_reg : fin_im;
            out_st_reg <= skid_valid_reg ? skid_st_reg : fin_st;
            out_eq_reg <= skid_valid_reg ? skid_eq_reg : fin_eq;
        end
        if (load_skid)
        begin
            skid_re_reg <= fin_re;
            skid_im_reg <= fin_im;
            skid_st_reg <= fin_st;
            skid_eq_reg <= fin_eq;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDW'({out_im_reg, out_re_reg});
    assign m_tuser  = {out_st_reg, out_eq_reg};

    // ---------------- checks ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while the output register is empty");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && v_reg[NS]) |=> v_reg[NS])
        else $error("last step stage dropped a word during a hold");

    a_div_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_st_reg == cau_pkg::ST_DIV_ZERO)
            |-> (out_re_reg == '0 && out_im_reg == '0 && !out_eq_reg))
        else $error("divide by zero result carries data");

    a_equal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_eq_reg)
            |-> (out_re_reg == '0 && out_im_reg == '0 && out_st_reg == cau_pkg::ST_OK))
        else $error("equal flag set with non-zero result or status");

endmodule
